// File: hw/rtl/neighbor_dipole_alignment_torque_defines.svh
// ----------------------------------------------------------------------------
// Assertion macros for the dipole alignment torque block
// Concurrent checks clocked by clk and held off while arst_n is low.
// Defining SYNTH compiles every check away.
// ----------------------------------------------------------------------------
`ifndef NEIGHBOR_DIPOLE_ALIGNMENT_TORQUE_DEFINES_SVH
`define NEIGHBOR_DIPOLE_ALIGNMENT_TORQUE_DEFINES_SVH

`ifndef SYNTH

// property must hold at every clock edge out of reset
`define NDAT_ASSERT(name, prop, msg) \
	name: assert property (@(posedge clk) disable iff (!arst_n) (prop)) else $error(msg);

// expression must never be true at a clock edge out of reset
`define NDAT_NEVER(name, expr, msg) \
	name: assert property (@(posedge clk) disable iff (!arst_n) !(expr)) else $error(msg);

`else

`define NDAT_ASSERT(name, prop, msg)

`define NDAT_NEVER(name, expr, msg)

`endif

`endif

// File: hw/rtl/ndat_pkg.sv
// ----------------------------------------------------------------------------
// ndat_pkg
// Shared types and constants of the dipole alignment torque block.
// ----------------------------------------------------------------------------
package ndat_pkg;

	// item codes on the op field
	typedef enum logic [1:0] {
		OP_BEGIN    = 2'd0,
		OP_NEIGHBOR = 2'd1,
		OP_END      = 2'd2
	} op_t;

	// one word in the front-to-back queue
	typedef struct packed {
		op_t              kind;
		logic [2:0][31:0] pos;
		logic [2:0][15:0] dip;
		logic             member;
	} q_entry_t;

	// configuration as seen by the back end
	typedef struct packed {
		logic [31:0] strength;
		logic [61:0] cutoff_sq;
		logic        nematic;
	} cfg_t;

	// multiply-accumulate lane widths
	localparam int MUL_A_W = 34;
	localparam int MUL_B_W = 19;
	localparam int PROD_W  = MUL_A_W + MUL_B_W;
	localparam int ACC_W   = 68;

	// torque sum width and saturation bounds
	localparam int SUM_W = 48;
	localparam logic [SUM_W-1:0] SUM_MAX = {1'b0, {(SUM_W-1){1'b1}}};
	localparam logic [SUM_W-1:0] SUM_MIN = {1'b1, {(SUM_W-1){1'b0}}};

	// what the accumulator does with the registered product
	typedef enum logic [1:0] {
		MAC_NONE,
		MAC_LOAD,
		MAC_ADD,
		MAC_SUB
	} mac_op_t;

	// left shift applied to the product before accumulation
	typedef enum logic [1:0] {
		SH_0,
		SH_16,
		SH_17,
		SH_18
	} mac_sh_t;

	typedef struct packed {
		mac_op_t op;
		mac_sh_t sh;
	} mac_cmd_t;

	// back-end sequencer
	typedef enum logic [4:0] {
		ST_IDLE,
		ST_DIFF,
		ST_SQ_LO,
		ST_SQ_HI,
		ST_SQ_ACC,
		ST_RSQ,
		ST_CMP,
		ST_DOT,
		ST_CR_A,
		ST_CR_B,
		ST_CR_ACC,
		ST_NEM_LO,
		ST_NEM_HI,
		ST_NEM_ACC,
		ST_K_LO,
		ST_K_HI,
		ST_K_ACC,
		ST_TERM,
		ST_SUM
	} back_state_t;

endpackage

// File: hw/rtl/ndat_fifo.sv
// ----------------------------------------------------------------------------
// ndat_fifo
// Short register queue between the front and the back end.
// ----------------------------------------------------------------------------
`include "neighbor_dipole_alignment_torque_defines.svh"

module ndat_fifo #(
	parameter int DEPTH = 4
) (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               push,
	input  ndat_pkg::q_entry_t wr_entry,
	input  logic               pop,
	output logic               full,
	output logic               not_empty,
	output ndat_pkg::q_entry_t rd_entry
);

	localparam int PTR_W = $clog2(DEPTH);
	localparam int CNT_W = $clog2(DEPTH + 1);

	ndat_pkg::q_entry_t mem_q [DEPTH];
	logic [PTR_W-1:0]   wr_ptr_q;
	logic [PTR_W-1:0]   rd_ptr_q;
	logic [CNT_W-1:0]   cnt_q;

	assign full      = (cnt_q == CNT_W'(DEPTH));
	assign not_empty = (cnt_q != '0);
	assign rd_entry  = mem_q[rd_ptr_q];

	// storage
	always_ff @(posedge clk) begin
		if (push) begin
			mem_q[wr_ptr_q] <= wr_entry;
		end
	end

	// pointers and fill count
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			cnt_q    <= '0;
		end else begin
			if (push) begin
				wr_ptr_q <= (wr_ptr_q == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr_q + 1'b1;
			end
			if (pop) begin
				rd_ptr_q <= (rd_ptr_q == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr_q + 1'b1;
			end
			if (push && !pop) begin
				cnt_q <= cnt_q + 1'b1;
			end else if (pop && !push) begin
				cnt_q <= cnt_q - 1'b1;
			end
		end
	end

	`NDAT_NEVER(a_no_overflow, push && full, "queue written while full")
	`NDAT_NEVER(a_no_underflow, pop && !not_empty, "queue read while empty")
	`NDAT_NEVER(a_cnt_in_range, cnt_q > CNT_W'(DEPTH), "queue fill count out of range")

endmodule

// File: hw/rtl/ndat_front.sv
// ----------------------------------------------------------------------------
// ndat_front
// Takes input words, drops those that can never contribute, and packs the
// rest into queue entries.
// ----------------------------------------------------------------------------
module ndat_front (
	input  logic               in_valid,
	output logic               in_ready,
	input  logic [1:0]         op,
	input  logic signed [31:0] pos_x,
	input  logic signed [31:0] pos_y,
	input  logic signed [31:0] pos_z,
	input  logic signed [15:0] dip_x,
	input  logic signed [15:0] dip_y,
	input  logic signed [15:0] dip_z,
	input  logic               in_group,
	input  logic               q_full,
	output logic               push,
	output ndat_pkg::q_entry_t entry
);

	// a word is taken whenever the queue has room, even if it is dropped
	assign in_ready = !q_full;

	// pack the payload
	always_comb begin
		entry.kind   = ndat_pkg::op_t'(op);
		entry.pos[0] = pos_x;
		entry.pos[1] = pos_y;
		entry.pos[2] = pos_z;
		entry.dip[0] = dip_x;
		entry.dip[1] = dip_y;
		entry.dip[2] = dip_z;
		entry.member = in_group;
	end

	// classify: neighbors outside the group and the unused code never reach the back
	always_comb begin
		push = 1'b0;
		if (in_valid && !q_full) begin
			case (op)
				ndat_pkg::OP_BEGIN:    push = 1'b1;
				ndat_pkg::OP_NEIGHBOR: push = in_group;
				ndat_pkg::OP_END:      push = 1'b1;
				default:               push = 1'b0;
			endcase
		end
	end

endmodule

// File: hw/rtl/ndat_mac.sv
// ----------------------------------------------------------------------------
// ndat_mac
// One axis lane: a 34x19 signed multiplier with a registered product and a
// shifting accumulator fed from that product register.
// ----------------------------------------------------------------------------
module ndat_mac (
	input  logic                                clk,
	input  logic                                arst_n,
	input  logic signed [ndat_pkg::MUL_A_W-1:0] mul_a,
	input  logic signed [ndat_pkg::MUL_B_W-1:0] mul_b,
	input  ndat_pkg::mac_cmd_t                  cmd,
	output logic signed [ndat_pkg::ACC_W-1:0]   acc
);

	localparam int EXT_W = ndat_pkg::ACC_W - ndat_pkg::PROD_W;

	logic signed [ndat_pkg::PROD_W-1:0] prod_s1;
	ndat_pkg::mac_cmd_t                 cmd_s1;
	logic signed [ndat_pkg::ACC_W-1:0]  acc_q;
	logic signed [ndat_pkg::ACC_W-1:0]  prod_ext;
	logic signed [ndat_pkg::ACC_W-1:0]  prod_sh;

	assign acc = acc_q;

	// multiply stage
	always_ff @(posedge clk) begin
		prod_s1 <= mul_a * mul_b;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cmd_s1 <= '{op: ndat_pkg::MAC_NONE, sh: ndat_pkg::SH_0};
		end else begin
			cmd_s1 <= cmd;
		end
	end

	// align the product
	always_comb begin
		prod_ext = $signed({{EXT_W{prod_s1[ndat_pkg::PROD_W-1]}}, prod_s1});
		case (cmd_s1.sh)
			ndat_pkg::SH_0:  prod_sh = prod_ext;
			ndat_pkg::SH_16: prod_sh = prod_ext <<< 16;
			ndat_pkg::SH_17: prod_sh = prod_ext <<< 17;
			ndat_pkg::SH_18: prod_sh = prod_ext <<< 18;
			default:         prod_sh = prod_ext;
		endcase
	end

	// accumulate stage
	always_ff @(posedge clk) begin
		case (cmd_s1.op)
			ndat_pkg::MAC_LOAD: acc_q <= prod_sh;
			ndat_pkg::MAC_ADD:  acc_q <= acc_q + prod_sh;
			ndat_pkg::MAC_SUB:  acc_q <= acc_q - prod_sh;
			default:            acc_q <= acc_q;
		endcase
	end

endmodule

// File: hw/rtl/ndat_back.sv
// ----------------------------------------------------------------------------
// ndat_back
// Executes queue entries: stores the center, runs the cutoff test and the
// torque term for each neighbor on three axis lanes, and emits the sums.
// ----------------------------------------------------------------------------
`include "neighbor_dipole_alignment_torque_defines.svh"

module ndat_back (
	input  logic                              clk,
	input  logic                              arst_n,
	input  ndat_pkg::cfg_t                    cfg,
	input  logic                              q_valid,
	input  ndat_pkg::q_entry_t                q_entry,
	output logic                              q_pop,
	output logic                              out_valid,
	input  logic                              out_ready,
	output logic signed [ndat_pkg::SUM_W-1:0] torque_x,
	output logic signed [ndat_pkg::SUM_W-1:0] torque_y,
	output logic signed [ndat_pkg::SUM_W-1:0] torque_z
);

	localparam int SW = ndat_pkg::SUM_W;
	localparam int AW = ndat_pkg::ACC_W;

	ndat_pkg::back_state_t state_q;
	ndat_pkg::back_state_t state_d;

	// center and neighbor
	logic signed [31:0] ctr_pos_q [3];
	logic signed [15:0] ctr_dip_q [3];
	logic               ctr_member_q;
	logic signed [31:0] nb_pos_q [3];
	logic signed [15:0] nb_dip_q [3];

	// working registers
	logic [30:0]          a_q [3];
	logic                 far_q;
	logic [62:0]          rsq_q;
	logic signed [32:0]   dot_q;
	logic signed [SW-1:0] term_q [3];
	logic signed [SW-1:0] sum_q [3];

	// output word
	logic                 out_valid_q;
	logic signed [SW-1:0] torque_q [3];

	// lane interface
	logic signed [ndat_pkg::MUL_A_W-1:0] mul_a [3];
	logic signed [ndat_pkg::MUL_B_W-1:0] mul_b [3];
	ndat_pkg::mac_cmd_t                  cmd [3];
	logic signed [AW-1:0]                acc [3];

	// control
	logic ld_center;
	logic ld_nb;
	logic ld_out;
	logic out_free;
	logic skip;

	// datapath helpers
	logic [32:0]        diff_w [3];
	logic [32:0]        mag_w [3];
	logic [63:0]        rsq_w;
	logic [33:0]        dot_w;
	logic signed [35:0] v_w [3];

	function automatic logic [SW-1:0] sat_term(input logic [51:0] x);
		logic fits;
		fits = (x[51:SW-1] == {(52-SW+1){x[51]}});
		if (fits) begin
			return x[SW-1:0];
		end
		return x[51] ? ndat_pkg::SUM_MIN : ndat_pkg::SUM_MAX;
	endfunction

	function automatic logic [SW-1:0] sat_add(input logic [SW-1:0] s, input logic [SW-1:0] t);
		logic [SW:0] r;
		r = {s[SW-1], s} + {t[SW-1], t};
		if (r[SW] == r[SW-1]) begin
			return r[SW-1:0];
		end
		return r[SW] ? ndat_pkg::SUM_MIN : ndat_pkg::SUM_MAX;
	endfunction

	assign out_free  = !out_valid_q || out_ready;
	assign out_valid = out_valid_q;
	assign torque_x  = torque_q[0];
	assign torque_y  = torque_q[1];
	assign torque_z  = torque_q[2];

	// per-axis distance, squared-distance total, cutoff test and dot-product sum
	always_comb begin
		for (int i = 0; i < 3; i++) begin
			diff_w[i] = {ctr_pos_q[i][31], ctr_pos_q[i]} - {nb_pos_q[i][31], nb_pos_q[i]};
			mag_w[i]  = diff_w[i][32] ? (33'd0 - diff_w[i]) : diff_w[i];
		end
		rsq_w = {1'b0, rsq_q} + {2'b00, acc[2][61:0]};
		skip  = far_q || (rsq_w >= {2'b00, cfg.cutoff_sq});
		dot_w = {{2{acc[0][31]}}, acc[0][31:0]} + {{2{acc[1][31]}}, acc[1][31:0]}
			+ {{2{acc[2][31]}}, acc[2][31:0]};
	end

	// pair weight: cross product alone, or dot times cross in nematic mode
	always_comb begin
		for (int i = 0; i < 3; i++) begin
			v_w[i] = cfg.nematic ? acc[i][63:28] : {{3{acc[i][32]}}, acc[i][32:0]};
		end
	end

	// next state
	always_comb begin
		state_d = state_q;
		case (state_q)
			ndat_pkg::ST_IDLE: begin
				if (q_valid && q_entry.kind == ndat_pkg::OP_NEIGHBOR && ctr_member_q) begin
					state_d = ndat_pkg::ST_DIFF;
				end
			end
			ndat_pkg::ST_DIFF:    state_d = ndat_pkg::ST_SQ_LO;
			ndat_pkg::ST_SQ_LO:   state_d = ndat_pkg::ST_SQ_HI;
			ndat_pkg::ST_SQ_HI:   state_d = ndat_pkg::ST_SQ_ACC;
			ndat_pkg::ST_SQ_ACC:  state_d = ndat_pkg::ST_RSQ;
			ndat_pkg::ST_RSQ:     state_d = ndat_pkg::ST_CMP;
			ndat_pkg::ST_CMP:     state_d = skip ? ndat_pkg::ST_IDLE : ndat_pkg::ST_DOT;
			ndat_pkg::ST_DOT:     state_d = ndat_pkg::ST_CR_A;
			ndat_pkg::ST_CR_A:    state_d = ndat_pkg::ST_CR_B;
			ndat_pkg::ST_CR_B:    state_d = ndat_pkg::ST_CR_ACC;
			ndat_pkg::ST_CR_ACC: begin
				state_d = cfg.nematic ? ndat_pkg::ST_NEM_LO : ndat_pkg::ST_K_LO;
			end
			ndat_pkg::ST_NEM_LO:  state_d = ndat_pkg::ST_NEM_HI;
			ndat_pkg::ST_NEM_HI:  state_d = ndat_pkg::ST_NEM_ACC;
			ndat_pkg::ST_NEM_ACC: state_d = ndat_pkg::ST_K_LO;
			ndat_pkg::ST_K_LO:    state_d = ndat_pkg::ST_K_HI;
			ndat_pkg::ST_K_HI:    state_d = ndat_pkg::ST_K_ACC;
			ndat_pkg::ST_K_ACC:   state_d = ndat_pkg::ST_TERM;
			ndat_pkg::ST_TERM:    state_d = ndat_pkg::ST_SUM;
			ndat_pkg::ST_SUM:     state_d = ndat_pkg::ST_IDLE;
			default:              state_d = ndat_pkg::ST_IDLE;
		endcase
	end

	// queue and register controls
	always_comb begin
		q_pop     = 1'b0;
		ld_center = 1'b0;
		ld_nb     = 1'b0;
		ld_out    = 1'b0;
		if (state_q == ndat_pkg::ST_IDLE && q_valid) begin
			case (q_entry.kind)
				ndat_pkg::OP_BEGIN: begin
					q_pop     = 1'b1;
					ld_center = 1'b1;
				end
				ndat_pkg::OP_NEIGHBOR: begin
					q_pop = 1'b1;
					ld_nb = ctr_member_q;
				end
				ndat_pkg::OP_END: begin
					q_pop  = out_free;
					ld_out = out_free;
				end
				default: q_pop = 1'b1;
			endcase
		end
	end

	// lane operands and accumulator commands
	for (genvar g = 0; g < 3; g++) begin : g_lane
		localparam int J = (g + 1) % 3;
		localparam int K = (g + 2) % 3;

		always_comb begin
			mul_a[g] = '0;
			mul_b[g] = '0;
			cmd[g]   = '{op: ndat_pkg::MAC_NONE, sh: ndat_pkg::SH_0};
			case (state_q)
				ndat_pkg::ST_SQ_LO: begin
					mul_a[g] = {3'b000, a_q[g]};
					mul_b[g] = {3'b000, a_q[g][15:0]};
					cmd[g]   = '{op: ndat_pkg::MAC_LOAD, sh: ndat_pkg::SH_0};
				end
				ndat_pkg::ST_SQ_HI: begin
					mul_a[g] = {3'b000, a_q[g]};
					mul_b[g] = {4'b0000, a_q[g][30:16]};
					cmd[g]   = '{op: ndat_pkg::MAC_ADD, sh: ndat_pkg::SH_16};
				end
				ndat_pkg::ST_DOT: begin
					mul_a[g] = {{18{ctr_dip_q[g][15]}}, ctr_dip_q[g]};
					mul_b[g] = {{3{nb_dip_q[g][15]}}, nb_dip_q[g]};
					cmd[g]   = '{op: ndat_pkg::MAC_LOAD, sh: ndat_pkg::SH_0};
				end
				ndat_pkg::ST_CR_A: begin
					mul_a[g] = {{18{ctr_dip_q[J][15]}}, ctr_dip_q[J]};
					mul_b[g] = {{3{nb_dip_q[K][15]}}, nb_dip_q[K]};
					cmd[g]   = '{op: ndat_pkg::MAC_LOAD, sh: ndat_pkg::SH_0};
				end
				ndat_pkg::ST_CR_B: begin
					mul_a[g] = {{18{ctr_dip_q[K][15]}}, ctr_dip_q[K]};
					mul_b[g] = {{3{nb_dip_q[J][15]}}, nb_dip_q[J]};
					cmd[g]   = '{op: ndat_pkg::MAC_SUB, sh: ndat_pkg::SH_0};
				end
				ndat_pkg::ST_NEM_LO: begin
					mul_a[g] = {dot_q[32], dot_q};
					mul_b[g] = {2'b00, acc[g][16:0]};
					cmd[g]   = '{op: ndat_pkg::MAC_LOAD, sh: ndat_pkg::SH_0};
				end
				ndat_pkg::ST_NEM_HI: begin
					mul_a[g] = {dot_q[32], dot_q};
					mul_b[g] = {{3{acc[g][32]}}, acc[g][32:17]};
					cmd[g]   = '{op: ndat_pkg::MAC_ADD, sh: ndat_pkg::SH_17};
				end
				ndat_pkg::ST_K_LO: begin
					mul_a[g] = {{2{cfg.strength[31]}}, cfg.strength};
					mul_b[g] = {1'b0, v_w[g][17:0]};
					cmd[g]   = '{op: ndat_pkg::MAC_LOAD, sh: ndat_pkg::SH_0};
				end
				ndat_pkg::ST_K_HI: begin
					mul_a[g] = {{2{cfg.strength[31]}}, cfg.strength};
					mul_b[g] = {v_w[g][35], v_w[g][35:18]};
					cmd[g]   = '{op: ndat_pkg::MAC_ADD, sh: ndat_pkg::SH_18};
				end
				default: begin
					mul_a[g] = '0;
				end
			endcase
		end

		ndat_mac u_mac (
			.clk   (clk),
			.arst_n(arst_n),
			.mul_a (mul_a[g]),
			.mul_b (mul_b[g]),
			.cmd   (cmd[g]),
			.acc   (acc[g])
		);
	end

	// sequencer state
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ndat_pkg::ST_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	// center, sums and output word
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			ctr_member_q <= 1'b0;
			out_valid_q  <= 1'b0;
			for (int i = 0; i < 3; i++) begin
				ctr_pos_q[i] <= '0;
				ctr_dip_q[i] <= '0;
				sum_q[i]     <= '0;
			end
		end else begin
			if (ld_center) begin
				ctr_member_q <= q_entry.member;
				for (int i = 0; i < 3; i++) begin
					ctr_pos_q[i] <= q_entry.pos[i];
					ctr_dip_q[i] <= q_entry.dip[i];
					sum_q[i]     <= '0;
				end
			end else if (state_q == ndat_pkg::ST_SUM) begin
				for (int i = 0; i < 3; i++) begin
					sum_q[i] <= sat_add(sum_q[i], term_q[i]);
				end
			end
			if (ld_out) begin
				out_valid_q <= 1'b1;
			end else if (out_ready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	// working registers
	always_ff @(posedge clk) begin
		if (ld_nb) begin
			for (int i = 0; i < 3; i++) begin
				nb_pos_q[i] <= q_entry.pos[i];
				nb_dip_q[i] <= q_entry.dip[i];
			end
		end
		if (ld_out) begin
			for (int i = 0; i < 3; i++) begin
				torque_q[i] <= sum_q[i];
			end
		end
		if (state_q == ndat_pkg::ST_DIFF) begin
			for (int i = 0; i < 3; i++) begin
				a_q[i] <= mag_w[i][30:0];
			end
			far_q <= (|mag_w[0][32:31]) | (|mag_w[1][32:31]) | (|mag_w[2][32:31]);
		end
		if (state_q == ndat_pkg::ST_RSQ) begin
			rsq_q <= {1'b0, acc[0][61:0]} + {1'b0, acc[1][61:0]};
		end
		// accumulators still hold the dot terms while the first cross term lands
		if (state_q == ndat_pkg::ST_CR_B) begin
			dot_q <= dot_w[32:0];
		end
		if (state_q == ndat_pkg::ST_TERM) begin
			for (int i = 0; i < 3; i++) begin
				term_q[i] <= sat_term(acc[i][AW-1:16]);
			end
		end
	end

	`NDAT_ASSERT(a_pop_idle, q_pop |-> (state_q == ndat_pkg::ST_IDLE),
		"queue popped while a neighbor is in progress")
	`NDAT_ASSERT(a_diff_after_pop, (state_q == ndat_pkg::ST_DIFF) |-> $past(q_pop),
		"neighbor started without a queue word")
	`NDAT_NEVER(a_no_out_overwrite, ld_out && out_valid_q && !out_ready,
		"pending torque word overwritten")

endmodule

// File: hw/rtl/neighbor_dipole_alignment_torque.sv
// ----------------------------------------------------------------------------
// neighbor_dipole_alignment_torque
// Dipole alignment torque on one center atom, summed over its neighbors.
// ----------------------------------------------------------------------------
// Send a begin word with the center atom, then its neighbors, then an end
// word, which returns one torque word. The front takes a word every cycle
// while the queue has room; neighbors outside the group and the unused op
// code are dropped there and cost nothing further. In the back end an end
// word waits for a free output register. A neighbor is only popped when the
// center is outside the group, stops after the compare when it fails the
// cutoff test, and else runs the whole state sequence, with the nematic
// steps in nematic mode: each axis lane has one 34x19 multiplier, and the
// squared distance, the cross and dot products and the strength product are
// built from its partial products in turn. Configuration writes are taken
// every cycle and must only be made while the block is idle.
// ----------------------------------------------------------------------------
module neighbor_dipole_alignment_torque #(
	parameter int QUEUE_DEPTH = 4
) (
	input  logic               clk,
	input  logic               arst_n,
	// item channel
	input  logic               in_valid,
	output logic               in_ready,
	input  logic [1:0]         op,
	input  logic signed [31:0] pos_x,
	input  logic signed [31:0] pos_y,
	input  logic signed [31:0] pos_z,
	input  logic signed [15:0] dip_x,
	input  logic signed [15:0] dip_y,
	input  logic signed [15:0] dip_z,
	input  logic               in_group,
	// result channel
	output logic               out_valid,
	input  logic               out_ready,
	output logic signed [47:0] torque_x,
	output logic signed [47:0] torque_y,
	output logic signed [47:0] torque_z,
	// configuration write channel
	input  logic               cfg_valid,
	output logic               cfg_ready,
	input  logic [1:0]         cfg_index,
	input  logic [61:0]        cfg_data
);

	// register indexes
	localparam logic [1:0] CFG_STRENGTH  = 2'd0;
	localparam logic [1:0] CFG_CUTOFF_SQ = 2'd1;
	localparam logic [1:0] CFG_NEMATIC   = 2'd2;

	// reset values: unit strength, unit squared cutoff, polar mode
	localparam logic [31:0] STRENGTH_RST  = 32'h0001_0000;
	localparam logic [61:0] CUTOFF_SQ_RST = 62'h1_0000_0000;

	ndat_pkg::cfg_t     cfg_q;
	ndat_pkg::q_entry_t push_entry;
	ndat_pkg::q_entry_t head_entry;
	logic               push;
	logic               pop;
	logic               q_full;
	logic               q_valid;

	assign cfg_ready = 1'b1;

	// configuration registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.strength  <= STRENGTH_RST;
			cfg_q.cutoff_sq <= CUTOFF_SQ_RST;
			cfg_q.nematic   <= 1'b0;
		end else if (cfg_valid && cfg_ready) begin
			case (cfg_index)
				CFG_STRENGTH:  cfg_q.strength  <= cfg_data[31:0];
				CFG_CUTOFF_SQ: cfg_q.cutoff_sq <= cfg_data;
				CFG_NEMATIC:   cfg_q.nematic   <= cfg_data[0];
				default:       cfg_q           <= cfg_q;
			endcase
		end
	end

	ndat_front u_front (
		.in_valid(in_valid),
		.in_ready(in_ready),
		.op      (op),
		.pos_x   (pos_x),
		.pos_y   (pos_y),
		.pos_z   (pos_z),
		.dip_x   (dip_x),
		.dip_y   (dip_y),
		.dip_z   (dip_z),
		.in_group(in_group),
		.q_full  (q_full),
		.push    (push),
		.entry   (push_entry)
	);

	ndat_fifo #(
		.DEPTH(QUEUE_DEPTH)
	) u_fifo (
		.clk      (clk),
		.arst_n   (arst_n),
		.push     (push),
		.wr_entry (push_entry),
		.pop      (pop),
		.full     (q_full),
		.not_empty(q_valid),
		.rd_entry (head_entry)
	);

	ndat_back u_back (
		.clk      (clk),
		.arst_n   (arst_n),
		.cfg      (cfg_q),
		.q_valid  (q_valid),
		.q_entry  (head_entry),
		.q_pop    (pop),
		.out_valid(out_valid),
		.out_ready(out_ready),
		.torque_x (torque_x),
		.torque_y (torque_y),
		.torque_z (torque_z)
	);

endmodule

// File: dv/ndat_tb_pkg.sv
// ----------------------------------------------------------------------------
// ndat_tb_pkg
// Register indexes, the spare op code and the torque word type that the
// checker and the stimulus of the alignment torque testbench share.
// ----------------------------------------------------------------------------
package ndat_tb_pkg;

	// configuration register indexes
	localparam logic [1:0] CFG_STRENGTH  = 2'd0;
	localparam logic [1:0] CFG_CUTOFF_SQ = 2'd1;
	localparam logic [1:0] CFG_NEMATIC   = 2'd2;

	// op code the block leaves unused
	localparam logic [1:0] OP_RESERVED = 2'd3;

	// one torque word as it leaves the block
	typedef struct packed {
		logic signed [47:0] x;
		logic signed [47:0] y;
		logic signed [47:0] z;
	} torque_word_t;

endpackage

// File: dv/ndat_torque_checker.sv
// ----------------------------------------------------------------------------
// ndat_torque_checker
// Watches the item, result and configuration channels of the alignment
// torque block, keeps its own copy of the center state, the sums and the
// registers, predicts each torque word and compares it field by field.
// ----------------------------------------------------------------------------
module ndat_torque_checker (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               in_valid,
	input  logic               in_ready,
	input  logic [1:0]         op,
	input  logic signed [31:0] pos_x,
	input  logic signed [31:0] pos_y,
	input  logic signed [31:0] pos_z,
	input  logic signed [15:0] dip_x,
	input  logic signed [15:0] dip_y,
	input  logic signed [15:0] dip_z,
	input  logic               in_group,
	input  logic               out_valid,
	input  logic               out_ready,
	input  logic signed [47:0] torque_x,
	input  logic signed [47:0] torque_y,
	input  logic signed [47:0] torque_z,
	input  logic               cfg_valid,
	input  logic               cfg_ready,
	input  logic [1:0]         cfg_index,
	input  logic [61:0]        cfg_data,
	output int                 fail_count,
	output int                 pending
);

	typedef logic signed [127:0] wide_t;

	localparam wide_t TORQUE_HI = 128'sh7FFF_FFFF_FFFF;
	localparam wide_t TORQUE_LO = -TORQUE_HI - 1;
	// any axis gap this large puts the pair past every cutoff
	localparam wide_t GAP_LIMIT = 128'sh8000_0000;

	// registers as last written
	logic signed [31:0] strength_k;
	logic [61:0]        cutoff_sq_r;
	logic               nematic_on;

	// center atom and running sums
	logic signed [31:0] ctr_pos [3];
	logic signed [15:0] ctr_dip [3];
	logic               ctr_member;
	logic signed [47:0] torque_acc [3];

	ndat_tb_pkg::torque_word_t torque_expected [$];
	ndat_tb_pkg::torque_word_t want;

	function automatic wide_t clamp48(input wide_t v);
		if (v > TORQUE_HI)
			return TORQUE_HI;
		if (v < TORQUE_LO)
			return TORQUE_LO;
		return v;
	endfunction

	function automatic wide_t abs_gap(input logic signed [31:0] a, input logic signed [31:0] b);
		wide_t aw;
		wide_t bw;
		wide_t d;
		aw = a;
		bw = b;
		d = aw - bw;
		return (d < 0) ? -d : d;
	endfunction

	// K times the cross term, weighted by the dot product in nematic mode
	function automatic wide_t torque_term(input wide_t cr_v, input wide_t dot);
		wide_t k;
		wide_t v;
		k = strength_k;
		v = nematic_on ? ((dot * cr_v) >>> 28) : cr_v;
		return clamp48((k * v) >>> 16);
	endfunction

	function automatic logic signed [47:0] add_sat(input logic signed [47:0] s, input wide_t t);
		wide_t sw;
		sw = s;
		return 48'(clamp48(sw + t));
	endfunction

	// one neighbor of a member center: cutoff test, then accumulate
	task automatic add_neighbor(
		input logic signed [31:0] px, input logic signed [31:0] py,
		input logic signed [31:0] pz, input logic signed [15:0] dx,
		input logic signed [15:0] dy, input logic signed [15:0] dz
	);
		wide_t gx, gy, gz, rsq;
		wide_t u0, u1, u2, w0, w1, w2;
		wide_t cr_x, cr_y, cr_z, dot;
		gx = abs_gap(ctr_pos[0], px);
		gy = abs_gap(ctr_pos[1], py);
		gz = abs_gap(ctr_pos[2], pz);
		if (gx >= GAP_LIMIT || gy >= GAP_LIMIT || gz >= GAP_LIMIT)
			return;
		rsq = gx * gx + gy * gy + gz * gz;
		if (rsq >= $signed({66'd0, cutoff_sq_r}))
			return;
		u0 = ctr_dip[0];
		u1 = ctr_dip[1];
		u2 = ctr_dip[2];
		w0 = dx;
		w1 = dy;
		w2 = dz;
		cr_x = u1 * w2 - u2 * w1;
		cr_y = u2 * w0 - u0 * w2;
		cr_z = u0 * w1 - u1 * w0;
		dot = u0 * w0 + u1 * w1 + u2 * w2;
		torque_acc[0] = add_sat(torque_acc[0], torque_term(cr_x, dot));
		torque_acc[1] = add_sat(torque_acc[1], torque_term(cr_y, dot));
		torque_acc[2] = add_sat(torque_acc[2], torque_term(cr_z, dot));
	endtask

	// advance the predicted state by one accepted item word
	task automatic accumulate_word();
		ndat_tb_pkg::torque_word_t w;
		case (op)
			ndat_pkg::OP_BEGIN: begin
				ctr_pos[0] = pos_x;
				ctr_pos[1] = pos_y;
				ctr_pos[2] = pos_z;
				ctr_dip[0] = dip_x;
				ctr_dip[1] = dip_y;
				ctr_dip[2] = dip_z;
				ctr_member = in_group;
				for (int i = 0; i < 3; i++)
					torque_acc[i] = '0;
			end
			ndat_pkg::OP_NEIGHBOR: begin
				if (ctr_member && in_group)
					add_neighbor(pos_x, pos_y, pos_z, dip_x, dip_y, dip_z);
			end
			ndat_pkg::OP_END: begin
				w.x = torque_acc[0];
				w.y = torque_acc[1];
				w.z = torque_acc[2];
				torque_expected.push_back(w);
			end
			default: ;
		endcase
	endtask

	task automatic report_mismatch(input string msg);
		$display("mismatch: %s", msg);
		fail_count++;
	endtask

	task automatic check_field(
		input string name, input logic signed [47:0] got, input logic signed [47:0] exp_v
	);
		if (got !== exp_v)
			report_mismatch($sformatf("%s got %0d expected %0d", name, got, exp_v));
	endtask

	// all channel activity, in a fixed order per edge
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			strength_k = 32'sd65536;
			cutoff_sq_r = 62'h1_0000_0000;
			nematic_on = 1'b0;
			ctr_member = 1'b0;
			for (int i = 0; i < 3; i++) begin
				ctr_pos[i] = '0;
				ctr_dip[i] = '0;
				torque_acc[i] = '0;
			end
			torque_expected.delete();
			fail_count = 0;
			pending <= 0;
		end else begin
			// a result word belongs to an end taken on an earlier edge
			if (out_valid && out_ready) begin
				if (torque_expected.size() == 0) begin
					report_mismatch("torque word with none expected");
				end else begin
					want = torque_expected.pop_front();
					check_field("torque_x", torque_x, want.x);
					check_field("torque_y", torque_y, want.y);
					check_field("torque_z", torque_z, want.z);
				end
			end
			// register writes
			if (cfg_valid && cfg_ready) begin
				case (cfg_index)
					ndat_tb_pkg::CFG_STRENGTH:  strength_k = cfg_data[31:0];
					ndat_tb_pkg::CFG_CUTOFF_SQ: cutoff_sq_r = cfg_data;
					ndat_tb_pkg::CFG_NEMATIC:   nematic_on = cfg_data[0];
					default: ;
				endcase
			end
			if (in_valid && in_ready)
				accumulate_word();
			pending <= torque_expected.size();
		end
	end

endmodule

// File: dv/tb_neighbor_dipole_alignment_torque.sv
// ----------------------------------------------------------------------------
// tb_neighbor_dipole_alignment_torque
// Stimulus for the alignment torque block: a directed run over the edge
// cases, then phases of random center/neighbor/end clusters under several
// register settings, with bursty input and a stalling output side. The
// checker beside the block predicts and compares every torque word.
// ----------------------------------------------------------------------------
module tb_neighbor_dipole_alignment_torque;

	localparam int SETTLE_CYCLES = 100;
	localparam int PHASES        = 10;
	localparam int PHASE_WORDS   = 140;

	localparam logic [31:0] POS_MAX = 32'h7FFF_FFFF;
	localparam logic [31:0] POS_MIN = 32'h8000_0000;
	localparam logic [31:0] POS_ONE = 32'h0001_0000;
	localparam logic [31:0] POS_HALF = 32'h0000_8000;
	localparam logic [15:0] DIP_MAX = 16'h7FFF;
	localparam logic [15:0] DIP_MIN = 16'h8000;
	localparam logic [15:0] DIP_ONE = 16'h4000;
	localparam logic [31:0] K_MAX   = 32'h7FFF_FFFF;
	localparam logic [31:0] K_MIN   = 32'h8000_0000;
	localparam logic [31:0] K_ONE   = 32'h0001_0000;
	localparam logic [61:0] CUT_MAX = {62{1'b1}};
	localparam logic [61:0] CUT_ONE = 62'h1_0000_0000;

	logic               clk;
	logic               arst_n;
	logic               in_valid;
	logic               in_ready;
	logic [1:0]         op;
	logic signed [31:0] pos_x;
	logic signed [31:0] pos_y;
	logic signed [31:0] pos_z;
	logic signed [15:0] dip_x;
	logic signed [15:0] dip_y;
	logic signed [15:0] dip_z;
	logic               in_group;
	logic               out_valid;
	logic               out_ready;
	logic signed [47:0] torque_x;
	logic signed [47:0] torque_y;
	logic signed [47:0] torque_z;
	logic               cfg_valid;
	logic               cfg_ready;
	logic [1:0]         cfg_index;
	logic [61:0]        cfg_data;

	int fail_count;
	int pending_words;
	int burst_left;
	int phase_items;
	logic [31:0] ctr_x, ctr_y, ctr_z;

	neighbor_dipole_alignment_torque uut (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (in_valid),
		.in_ready  (in_ready),
		.op        (op),
		.pos_x     (pos_x),
		.pos_y     (pos_y),
		.pos_z     (pos_z),
		.dip_x     (dip_x),
		.dip_y     (dip_y),
		.dip_z     (dip_z),
		.in_group  (in_group),
		.out_valid (out_valid),
		.out_ready (out_ready),
		.torque_x  (torque_x),
		.torque_y  (torque_y),
		.torque_z  (torque_z),
		.cfg_valid (cfg_valid),
		.cfg_ready (cfg_ready),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data)
	);

	ndat_torque_checker checker_i (
		.clk        (clk),
		.arst_n     (arst_n),
		.in_valid   (in_valid),
		.in_ready   (in_ready),
		.op         (op),
		.pos_x      (pos_x),
		.pos_y      (pos_y),
		.pos_z      (pos_z),
		.dip_x      (dip_x),
		.dip_y      (dip_y),
		.dip_z      (dip_z),
		.in_group   (in_group),
		.out_valid  (out_valid),
		.out_ready  (out_ready),
		.torque_x   (torque_x),
		.torque_y   (torque_y),
		.torque_z   (torque_z),
		.cfg_valid  (cfg_valid),
		.cfg_ready  (cfg_ready),
		.cfg_index  (cfg_index),
		.cfg_data   (cfg_data),
		.fail_count (fail_count),
		.pending    (pending_words)
	);

	initial begin
		clk = 1'b0;
		forever #1 clk = ~clk;
	end

	// bursts of back-to-back words with idle gaps between them
	task automatic pace_sender();
		int gap;
		if (burst_left == 0) begin
			burst_left = $urandom_range(1, 40);
			gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 8);
			if (gap > 0) begin
				in_valid <= 1'b0;
				repeat (gap) @(posedge clk);
			end
		end
		burst_left--;
	endtask

	task automatic send_word(
		input logic [1:0] code, input logic [31:0] px, input logic [31:0] py,
		input logic [31:0] pz, input logic [15:0] dx, input logic [15:0] dy,
		input logic [15:0] dz, input logic grp
	);
		pace_sender();
		in_valid <= 1'b1;
		op <= code;
		pos_x <= px;
		pos_y <= py;
		pos_z <= pz;
		dip_x <= dx;
		dip_y <= dy;
		dip_z <= dz;
		in_group <= grp;
		@(posedge clk);
		while (!in_ready)
			@(posedge clk);
		if (code != ndat_tb_pkg::OP_RESERVED)
			phase_items++;
	endtask

	// stop sending, wait for every torque word, then let the back end settle
	task automatic drain();
		in_valid <= 1'b0;
		@(posedge clk);
		while (pending_words != 0)
			@(posedge clk);
		repeat (SETTLE_CYCLES) @(posedge clk);
	endtask

	task automatic write_reg(input logic [1:0] idx, input logic [61:0] data);
		cfg_valid <= 1'b1;
		cfg_index <= idx;
		cfg_data <= data;
		@(posedge clk);
		while (!cfg_ready)
			@(posedge clk);
	endtask

	task automatic apply_setting(input logic [31:0] k, input logic [61:0] cut, input logic nem);
		drain();
		write_reg(ndat_tb_pkg::CFG_STRENGTH, {30'd0, k});
		write_reg(ndat_tb_pkg::CFG_CUTOFF_SQ, cut);
		write_reg(ndat_tb_pkg::CFG_NEMATIC, {61'd0, nem});
		cfg_valid <= 1'b0;
	endtask

	function automatic logic [15:0] pick_dip();
		case ($urandom_range(0, 7))
			0: return DIP_MAX;
			1: return DIP_MIN;
			2: return 16'h0000;
			default: return 16'($urandom);
		endcase
	endfunction

	function automatic logic [31:0] pick_coord();
		case ($urandom_range(0, 9))
			0: return POS_MAX;
			1: return POS_MIN;
			2: return 32'h0;
			default: return $urandom;
		endcase
	endfunction

	// neighbor coordinate: mostly within a cutoff or two of the center
	function automatic logic [31:0] pick_near(input logic [31:0] c);
		int unsigned span;
		case ($urandom_range(0, 9))
			0, 1, 2: span = 32'h0000_1000;
			3, 4, 5: span = 32'h0000_8000;
			6, 7: span = 32'h0002_0000;
			8: span = 32'h0100_0000;
			default: return $urandom;
		endcase
		return c + $urandom_range(0, 2 * span) - span;
	endfunction

	function automatic logic [31:0] pick_strength();
		case ($urandom_range(0, 5))
			0: return K_MAX;
			1: return K_MIN;
			2: return K_ONE;
			3: return -K_ONE;
			4: return 32'h0;
			default: return $urandom;
		endcase
	endfunction

	function automatic logic [61:0] pick_cutoff();
		case ($urandom_range(0, 6))
			0: return CUT_MAX;
			1: return 62'd1;
			2: return 62'd0;
			3: return CUT_ONE;
			4: return CUT_ONE << 2;
			5: return CUT_ONE >> 4;
			default: return 62'({$urandom, $urandom});
		endcase
	endfunction

	// begin word, a run of neighbors, end word, now and then a second end
	task automatic send_cluster();
		int n;
		ctr_x = pick_coord();
		ctr_y = pick_coord();
		ctr_z = pick_coord();
		send_word(ndat_pkg::OP_BEGIN, ctr_x, ctr_y, ctr_z, pick_dip(), pick_dip(), pick_dip(),
			$urandom_range(0, 9) != 0);
		n = ($urandom_range(0, 7) == 0) ? $urandom_range(8, 16) : $urandom_range(0, 6);
		repeat (n)
			send_word(ndat_pkg::OP_NEIGHBOR, pick_near(ctr_x), pick_near(ctr_y),
				pick_near(ctr_z), pick_dip(), pick_dip(), pick_dip(),
				$urandom_range(0, 7) != 0);
		send_word(ndat_pkg::OP_END, $urandom, $urandom, $urandom, 16'($urandom),
			16'($urandom), 16'($urandom), 1'($urandom));
		if ($urandom_range(0, 6) == 0)
			send_word(ndat_pkg::OP_END, $urandom, $urandom, $urandom, 16'($urandom),
				16'($urandom), 16'($urandom), 1'($urandom));
	endtask

	// fully random word, spare op code included
	task automatic send_noise();
		send_word(2'($urandom_range(0, 3)), $urandom, $urandom, $urandom, 16'($urandom),
			16'($urandom), 16'($urandom), 1'($urandom));
	endtask

	// result side: stall patterns, each held for a random run
	initial begin
		int mode;
		int len;
		out_ready <= 1'b0;
		forever begin
			mode = $urandom_range(0, 3);
			len = $urandom_range(8, 200);
			for (int c = 0; c < len; c++) begin
				@(posedge clk);
				case (mode)
					0: out_ready <= 1'b1;
					1: out_ready <= 1'($urandom_range(0, 1));
					2: out_ready <= ($urandom_range(0, 7) == 0);
					default: out_ready <= (c % 5) != 0;
				endcase
			end
		end
	end

	initial begin
		#1000000;
		$display("tb_neighbor_dipole_alignment_torque NOT OK");
		$finish;
	end

	initial begin
		arst_n <= 1'b0;
		in_valid <= 1'b0;
		op <= ndat_pkg::OP_BEGIN;
		pos_x <= '0;
		pos_y <= '0;
		pos_z <= '0;
		dip_x <= '0;
		dip_y <= '0;
		dip_z <= '0;
		in_group <= 1'b0;
		cfg_valid <= 1'b0;
		cfg_index <= ndat_tb_pkg::CFG_STRENGTH;
		cfg_data <= '0;
		burst_left = 0;
		phase_items = 0;
		repeat (3) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// reset registers: K = 1.0, cutoff 1.0, polar
		// neighbor before any begin sees a non-member center
		send_word(ndat_pkg::OP_NEIGHBOR, 32'h0, 32'h0, 32'h0, DIP_ONE, DIP_ONE, 16'h0,
			1'b1);
		// end without begin
		send_word(ndat_pkg::OP_END, 32'h0, 32'h0, 32'h0, 16'h0, 16'h0, 16'h0, 1'b0);
		// spare op code, all ones
		send_word(ndat_tb_pkg::OP_RESERVED, '1, '1, '1, '1, '1, '1, 1'b1);
		send_word(ndat_pkg::OP_BEGIN, 32'h0, 32'h0, 32'h0, DIP_ONE, 16'h0, 16'h0, 1'b1);
		send_word(ndat_pkg::OP_NEIGHBOR, POS_HALF, 32'h0, 32'h0, 16'h0, DIP_ONE, 16'h0,
			1'b1);
		// neighbor outside the group
		send_word(ndat_pkg::OP_NEIGHBOR, 32'h0, 32'h0, 32'h0, 16'h0, 16'h0, DIP_ONE,
			1'b0);
		// squared distance exactly at the cutoff
		send_word(ndat_pkg::OP_NEIGHBOR, POS_ONE, 32'h0, 32'h0, 16'h0, DIP_ONE, 16'h0,
			1'b1);
		// axis gap of 2^31
		send_word(ndat_pkg::OP_NEIGHBOR, POS_MIN, 32'h0, 32'h0, 16'h0, DIP_ONE, 16'h0,
			1'b1);
		send_word(ndat_pkg::OP_NEIGHBOR, 32'h1, 32'h1, 32'h1, DIP_MIN, DIP_MIN, DIP_MIN,
			1'b1);
		send_word(ndat_pkg::OP_NEIGHBOR, 32'h0, 32'h0, 32'h0, DIP_MAX, DIP_MIN, DIP_MAX,
			1'b1);
		send_word(ndat_pkg::OP_END, 32'h0, 32'h0, 32'h0, 16'h0, 16'h0, 16'h0, 1'b1);
		// repeated end
		send_word(ndat_pkg::OP_END, '1, '1, '1, '1, '1, '1, 1'b1);
		// center outside the group
		send_word(ndat_pkg::OP_BEGIN, POS_MAX, POS_MAX, POS_MAX, DIP_MIN, DIP_MAX, DIP_MIN,
			1'b0);
		send_word(ndat_pkg::OP_NEIGHBOR, POS_MAX, POS_MAX, POS_MAX, DIP_MAX, DIP_MAX,
			DIP_MAX, 1'b1);
		send_word(ndat_pkg::OP_END, 32'h0, 32'h0, 32'h0, 16'h0, 16'h0, 16'h0, 1'b0);
		// extreme corners
		send_word(ndat_pkg::OP_BEGIN, POS_MIN, POS_MIN, POS_MIN, DIP_MIN, DIP_MIN, DIP_MAX,
			1'b1);
		send_word(ndat_pkg::OP_NEIGHBOR, POS_MAX, POS_MIN, POS_MIN, DIP_MAX, DIP_MAX,
			DIP_MAX, 1'b1);
		send_word(ndat_pkg::OP_NEIGHBOR, POS_MIN, POS_MIN, POS_MIN, DIP_MAX, DIP_MIN,
			DIP_MIN, 1'b1);
		send_word(ndat_pkg::OP_END, 32'h0, 32'h0, 32'h0, 16'h0, 16'h0, 16'h0, 1'b1);

		// largest K, nematic weighting: terms and sums saturate
		apply_setting(K_MAX, CUT_MAX, 1'b1);
		send_word(ndat_pkg::OP_BEGIN, 32'h0, 32'h0, 32'h0, DIP_MIN, DIP_MAX, DIP_MIN, 1'b1);
		repeat (3)
			send_word(ndat_pkg::OP_NEIGHBOR, POS_HALF, 32'h0, 32'h0, DIP_MAX, DIP_MAX,
				DIP_MIN, 1'b1);
		send_word(ndat_pkg::OP_END, 32'h0, 32'h0, 32'h0, 16'h0, 16'h0, 16'h0, 1'b1);

		// zero cutoff skips even a coincident neighbor
		apply_setting(K_MIN, 62'd0, 1'b0);
		send_word(ndat_pkg::OP_BEGIN, 32'h0, 32'h0, 32'h0, DIP_ONE, 16'h0, 16'h0, 1'b1);
		send_word(ndat_pkg::OP_NEIGHBOR, 32'h0, 32'h0, 32'h0, 16'h0, DIP_ONE, 16'h0,
			1'b1);
		send_word(ndat_pkg::OP_END, 32'h0, 32'h0, 32'h0, 16'h0, 16'h0, 16'h0, 1'b1);

		// random phases, each under its own register setting
		for (int ph = 0; ph < PHASES; ph++) begin
			case (ph)
				0: apply_setting(K_MAX, CUT_MAX, 1'b0);
				1: apply_setting(K_MIN, CUT_ONE << 2, 1'b1);
				2: apply_setting(K_ONE, 62'd1, 1'b1);
				3: apply_setting(K_MIN, CUT_MAX, 1'b1);
				default: apply_setting(pick_strength(), pick_cutoff(), 1'($urandom));
			endcase
			phase_items = 0;
			while (phase_items < PHASE_WORDS) begin
				if ($urandom_range(0, 99) < 88)
					send_cluster();
				else
					send_noise();
			end
		end

		drain();
		if (fail_count == 0) begin
			$display("tb_neighbor_dipole_alignment_torque OK");
		end else begin
			$display("tb_neighbor_dipole_alignment_torque NOT OK");
		end
		$finish;
	end

endmodule
